@@ design/bsmt_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bitmap set package
// Operation and status codes, sequencer states and a word helper used by
// the bitmap set with minimum tracking.
// ----------------------------------------------------------------------------
package bsmt_pkg;

  localparam int WORD_W = 16;
  localparam int OFF_W  = 4;

  localparam logic [2:0] OP_SET       = 3'd0;
  localparam logic [2:0] OP_UNSET     = 3'd1;
  localparam logic [2:0] OP_TEST      = 3'd2;
  localparam logic [2:0] OP_POP       = 3'd3;
  localparam logic [2:0] OP_SET_ALL   = 3'd4;
  localparam logic [2:0] OP_CLEAR_ALL = 3'd5;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_BOUNDS = 2'd1;
  localparam logic [1:0] ST_EMPTY  = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MODIFY,
    S_SCAN_RD,
    S_SCAN_CHK,
    S_FILL,
    S_DONE
  } state_t;

  function automatic logic [OFF_W-1:0] lowest_bit(input logic [WORD_W-1:0] w);
    logic [OFF_W-1:0] pos;
    pos = '0;
    for (int i = WORD_W - 1; i >= 0; i--) begin
      if (w[i]) begin
        pos = OFF_W'(i);
      end
    end
    return pos;
  endfunction

endpackage

@@ design/bitmap_set_with_min_tracking.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bitmap set with minimum tracking
// Membership bitmap held as 16-bit words in one memory, with a live count,
// the lowest member and an all-set flag. A small sequencer reads, modifies
// and writes one word per step and walks words upward to find a new head.
// ----------------------------------------------------------------------------
// Set, unset and pop read one word and write it back; test only reads it. A
// rescan for a new head reads words upward from the removed member until one
// holds a member or the last word is passed. Set all and clear all write one
// word per cycle over all words. One item is in work at a time.
// Reset and every capacity write start a clearing pass over all NWORDS words,
// NWORDS = ceil(min(MAX_ELEMENTS, 511) / 16), during which no item is taken.
module bitmap_set_with_min_tracking
  import bsmt_pkg::*;
#(
  parameter int MAX_ELEMENTS = 256
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [2:0] in_op,
  input  logic [7:0] in_index,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       out_was_member,
  output logic [7:0] out_popped_index,
  output logic [7:0] out_head_index,
  output logic       out_head_valid,
  output logic [8:0] out_member_count,
  output logic       out_all_set,
  output logic [1:0] out_status,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [8:0] cfg_capacity
);

  localparam int CAP_MAX = (MAX_ELEMENTS < 511) ? MAX_ELEMENTS : 511;
  localparam int NWORDS  = (CAP_MAX + WORD_W - 1) / WORD_W;
  localparam int AW      = (NWORDS > 1) ? $clog2(NWORDS) : 1;
  localparam int POS_W   = AW + OFF_W;
  localparam int CNT_W   = $clog2(CAP_MAX + 1);

  state_t                state_r, state_nxt;
  logic [2:0]            op_r, op_nxt;
  logic [POS_W-1:0]      pos_r, pos_nxt;
  logic                  was_r, was_nxt;
  logic [7:0]            popped_r, popped_nxt;
  logic [1:0]            status_r, status_nxt;
  logic [POS_W-1:0]      head_r, head_nxt;
  logic                  hv_r, hv_nxt;
  logic [CNT_W-1:0]      cnt_r, cnt_nxt;
  logic [CNT_W-1:0]      cap_r, cap_nxt;
  logic [AW:0]           scan_w_r, scan_w_nxt;
  logic [OFF_W-1:0]      scan_off_r, scan_off_nxt;
  logic [AW-1:0]         fill_w_r, fill_w_nxt;
  logic                  fill_set_r, fill_set_nxt;
  logic                  fill_rpt_r, fill_rpt_nxt;

  logic                  out_valid_r, out_valid_nxt;
  logic                  out_was_r, out_was_nxt;
  logic [7:0]            out_popped_r, out_popped_nxt;
  logic [7:0]            out_head_r, out_head_nxt;
  logic                  out_hv_r, out_hv_nxt;
  logic [8:0]            out_cnt_r, out_cnt_nxt;
  logic                  out_all_r, out_all_nxt;
  logic [1:0]            out_status_r, out_status_nxt;

  logic                  ram_we;
  logic [AW-1:0]         ram_waddr;
  logic [WORD_W-1:0]     ram_wdata;
  logic                  ram_re;
  logic [AW-1:0]         ram_raddr;
  logic [WORD_W-1:0]     ram_rdata;

  logic                  accept;
  logic [POS_W-1:0]      in_pos;
  logic [POS_W:0]        cap_x;
  logic [POS_W:0]        last_pos;
  logic [AW:0]           last_w;
  logic [AW:0]           full_w;
  logic [AW:0]           fill_k;
  logic [WORD_W-1:0]     fill_mask;
  logic [OFF_W-1:0]      off;
  logic [WORD_W-1:0]     bit_sel;
  logic                  cur_bit;
  logic [POS_W:0]        next_pos;
  logic [WORD_W-1:0]     scan_masked;
  logic                  out_free;

  bsmt_ram #(
    .WIDTH (WORD_W),
    .DEPTH (NWORDS)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_en   (ram_re),
    .rd_addr (ram_raddr),
    .rd_data (ram_rdata)
  );

  assign cfg_ready = 1'b1;
  assign in_stall  = (state_r != S_IDLE);
  assign accept    = in_valid && (state_r == S_IDLE);
  assign in_pos    = POS_W'(in_index);
  assign out_free  = !out_valid_r || !out_stall;

  assign cap_x     = (POS_W + 1)'(cap_r);
  assign last_pos  = cap_x - (POS_W + 1)'(1);
  assign last_w    = last_pos[POS_W:OFF_W];
  assign full_w    = cap_x[POS_W:OFF_W];
  assign fill_k    = (AW + 1)'(fill_w_r);

  always_comb begin
    if (fill_k < full_w) begin
      fill_mask = '1;
    end else if (fill_k == full_w) begin
      fill_mask = (WORD_W'(1) << cap_x[OFF_W-1:0]) - WORD_W'(1);
    end else begin
      fill_mask = '0;
    end
  end

  assign off         = pos_r[OFF_W-1:0];
  assign bit_sel     = WORD_W'(1) << off;
  assign cur_bit     = |(ram_rdata & bit_sel);
  assign next_pos    = (POS_W + 1)'(pos_r) + (POS_W + 1)'(1);
  assign scan_masked = ram_rdata & ({WORD_W{1'b1}} << scan_off_r);

  always_comb begin
    state_nxt      = state_r;
    op_nxt         = op_r;
    pos_nxt        = pos_r;
    was_nxt        = was_r;
    popped_nxt     = popped_r;
    status_nxt     = status_r;
    head_nxt       = head_r;
    hv_nxt         = hv_r;
    cnt_nxt        = cnt_r;
    cap_nxt        = cap_r;
    scan_w_nxt     = scan_w_r;
    scan_off_nxt   = scan_off_r;
    fill_w_nxt     = fill_w_r;
    fill_set_nxt   = fill_set_r;
    fill_rpt_nxt   = fill_rpt_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_was_nxt    = out_was_r;
    out_popped_nxt = out_popped_r;
    out_head_nxt   = out_head_r;
    out_hv_nxt     = out_hv_r;
    out_cnt_nxt    = out_cnt_r;
    out_all_nxt    = out_all_r;
    out_status_nxt = out_status_r;
    ram_we         = 1'b0;
    ram_waddr      = pos_r[POS_W-1:OFF_W];
    ram_wdata      = ram_rdata;
    ram_re         = 1'b0;
    ram_raddr      = in_pos[POS_W-1:OFF_W];

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          op_nxt     = in_op;
          pos_nxt    = in_pos;
          was_nxt    = 1'b0;
          popped_nxt = '0;
          status_nxt = ST_OK;
          case (in_op) inside
            OP_SET, OP_UNSET, OP_TEST: begin
              if (9'(in_index) >= 9'(cap_r)) begin
                status_nxt = ST_BOUNDS;
                state_nxt  = S_DONE;
              end else begin
                ram_re    = 1'b1;
                state_nxt = S_MODIFY;
              end
            end
            OP_POP: begin
              if (!hv_r) begin
                status_nxt = ST_EMPTY;
                state_nxt  = S_DONE;
              end else begin
                pos_nxt    = head_r;
                popped_nxt = 8'(head_r);
                ram_re     = 1'b1;
                ram_raddr  = head_r[POS_W-1:OFF_W];
                state_nxt  = S_MODIFY;
              end
            end
            OP_SET_ALL, OP_CLEAR_ALL: begin
              fill_w_nxt   = '0;
              fill_set_nxt = (in_op == OP_SET_ALL);
              fill_rpt_nxt = 1'b1;
              state_nxt    = S_FILL;
            end
            default: begin
              state_nxt = S_DONE;
            end
          endcase
        end
      end
      S_MODIFY: begin
        state_nxt = S_DONE;
        was_nxt   = cur_bit;
        case (op_r)
          OP_SET: begin
            ram_we    = 1'b1;
            ram_wdata = ram_rdata | bit_sel;
            if (!cur_bit) begin
              cnt_nxt = cnt_r + CNT_W'(1);
            end
            if (!hv_r || (pos_r < head_r)) begin
              head_nxt = pos_r;
              hv_nxt   = 1'b1;
            end
          end
          OP_UNSET, OP_POP: begin
            ram_we    = 1'b1;
            ram_wdata = ram_rdata & ~bit_sel;
            if (op_r == OP_POP) begin
              was_nxt = 1'b1;
            end
            if (cur_bit) begin
              cnt_nxt = cnt_r - CNT_W'(1);
            end
            if (hv_r && (head_r == pos_r)) begin
              head_nxt     = '0;
              hv_nxt       = 1'b0;
              scan_w_nxt   = next_pos[POS_W:OFF_W];
              scan_off_nxt = next_pos[OFF_W-1:0];
              state_nxt    = S_SCAN_RD;
            end
          end
          default: begin
          end
        endcase
      end
      S_SCAN_RD: begin
        if (scan_w_r > last_w) begin
          state_nxt = S_DONE;
        end else begin
          ram_re    = 1'b1;
          ram_raddr = scan_w_r[AW-1:0];
          state_nxt = S_SCAN_CHK;
        end
      end
      S_SCAN_CHK: begin
        if (|scan_masked) begin
          head_nxt  = {scan_w_r[AW-1:0], lowest_bit(scan_masked)};
          hv_nxt    = 1'b1;
          state_nxt = S_DONE;
        end else begin
          scan_w_nxt   = scan_w_r + (AW + 1)'(1);
          scan_off_nxt = '0;
          state_nxt    = S_SCAN_RD;
        end
      end
      S_FILL: begin
        ram_we     = 1'b1;
        ram_waddr  = fill_w_r;
        ram_wdata  = fill_set_r ? fill_mask : '0;
        fill_w_nxt = fill_w_r + AW'(1);
        if (fill_w_r == AW'(NWORDS - 1)) begin
          head_nxt  = '0;
          hv_nxt    = fill_set_r;
          cnt_nxt   = fill_set_r ? cap_r : '0;
          state_nxt = fill_rpt_r ? S_DONE : S_IDLE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_was_nxt    = was_r;
          out_popped_nxt = popped_r;
          out_head_nxt   = hv_r ? 8'(head_r) : 8'd0;
          out_hv_nxt     = hv_r;
          out_cnt_nxt    = 9'(cnt_r);
          out_all_nxt    = (cnt_r == cap_r);
          out_status_nxt = status_r;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (cfg_valid) begin
      if (cfg_capacity == 9'd0) begin
        cap_nxt = CNT_W'(1);
      end else if (int'(cfg_capacity) > CAP_MAX) begin
        cap_nxt = CNT_W'(CAP_MAX);
      end else begin
        cap_nxt = CNT_W'(cfg_capacity);
      end
      head_nxt     = '0;
      hv_nxt       = 1'b0;
      cnt_nxt      = '0;
      fill_w_nxt   = '0;
      fill_set_nxt = 1'b0;
      fill_rpt_nxt = 1'b0;
      state_nxt    = S_FILL;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_FILL;
      head_r      <= '0;
      hv_r        <= 1'b0;
      cnt_r       <= '0;
      cap_r       <= CNT_W'((CAP_MAX < 256) ? CAP_MAX : 256);
      fill_w_r    <= '0;
      fill_set_r  <= 1'b0;
      fill_rpt_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      hv_r        <= hv_nxt;
      cnt_r       <= cnt_nxt;
      cap_r       <= cap_nxt;
      fill_w_r    <= fill_w_nxt;
      fill_set_r  <= fill_set_nxt;
      fill_rpt_r  <= fill_rpt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r         <= op_nxt;
    pos_r        <= pos_nxt;
    was_r        <= was_nxt;
    popped_r     <= popped_nxt;
    status_r     <= status_nxt;
    scan_w_r     <= scan_w_nxt;
    scan_off_r   <= scan_off_nxt;
    out_was_r    <= out_was_nxt;
    out_popped_r <= out_popped_nxt;
    out_head_r   <= out_head_nxt;
    out_hv_r     <= out_hv_nxt;
    out_cnt_r    <= out_cnt_nxt;
    out_all_r    <= out_all_nxt;
    out_status_r <= out_status_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_was_member   = out_was_r;
  assign out_popped_index = out_popped_r;
  assign out_head_index   = out_head_r;
  assign out_head_valid   = out_hv_r;
  assign out_member_count = out_cnt_r;
  assign out_all_set      = out_all_r;
  assign out_status       = out_status_r;

endmodule

@@ design/bsmt_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic word memory
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module bsmt_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  logic                                  clk,
  input  logic                                  wr_en,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                      wr_data,
  input  logic                                  rd_en,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                      rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
